// File: hw/rtl/oaht_pkg.sv
// shared constants, types and a helper function of the open-addressed hash table
package oaht_pkg;

	// table geometry, capacity is a power of two so the home slot is a mask
	localparam int CAPACITY    = 64;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int KEY_BYTES   = 4;
	localparam int VALUE_BYTES = 4;
	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 7;
	localparam int OP_W        = 2;
	localparam int BYTE_CNT_W  = $clog2(KEY_BYTES + 1);

	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 4) ? '1 :
		KEY_W'((64'd1 << (8 * KEY_BYTES)) - 64'd1);
	localparam logic [VALUE_W-1:0] VALUE_MASK = (VALUE_BYTES >= 4) ? '1 :
		VALUE_W'((64'd1 << (8 * VALUE_BYTES)) - 64'd1);

	// fnv-1a
	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

	typedef enum logic [OP_W-1:0] {
		OP_PUT = 2'd0,
		OP_GET = 2'd1,
		OP_DEL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MARK_EMPTY  = 2'd0,
		MARK_FILLED = 2'd1,
		MARK_TOMB   = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_REPLY
	} state_t;

	typedef struct packed {
		mark_t              mark;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} slot_word_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} slot_rd_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_word_t        data;
	} slot_wr_t;

	// one fnv-1a round: xor in a byte, multiply by the prime
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return 32'(x * FNV_PRIME);
	endfunction

endpackage

// File: hw/rtl/oaht_if.sv
// request and response channel interfaces of the hash table
interface oaht_req_if;
	import oaht_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [KEY_W-1:0]   key;
	logic [VALUE_W-1:0] value;

	modport source (output valid, op, key, value, input ready);
	modport sink   (input valid, op, key, value, output ready);
endinterface

interface oaht_rsp_if;
	import oaht_pkg::*;

	logic               valid;
	logic               ready;
	logic               found;
	logic [VALUE_W-1:0] value_out;
	logic               status;
	logic [COUNT_W-1:0] entry_count;

	modport source (output valid, found, value_out, status, entry_count, input ready);
	modport sink   (input valid, found, value_out, status, entry_count, output ready);
endinterface

// File: hw/rtl/open_addressed_hash_table.sv
// top level of the open-addressed hash table with linear probing
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+--------------------------------------------
//  req     | in  | valid / ready | op, key, value
//  rsp     | out | valid / ready | found, value_out, status, entry_count
//
// one operation at a time: accept, then the hash (one fnv round per cycle, then the
// home slot read), then the probe walk through the registered slot memory, then the
// reply; the probe length is 1 to CAPACITY slots, set by the occupancy near the home
// slot; op 3 and delete on an empty table skip hashing and probing and go to the reply
// reset clears the fsm, the entry count and the per-slot written flags at once
// a reply held by rsp.ready keeps the fsm in reply, one word can wait behind it
module open_addressed_hash_table (
	input logic     clk,
	input logic     arst_n,
	oaht_req_if.sink   req,
	oaht_rsp_if.source rsp
);
	import oaht_pkg::*;

	state_t state_q, state_d;

	// captured request
	logic [OP_W-1:0]    op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] val_q;

	// probe walk
	logic [SLOT_W-1:0]  idx_q;
	logic [SLOT_W-1:0]  probe_cnt_q;
	logic               have_tomb_q;
	logic [SLOT_W-1:0]  tomb_q;

	// pending result and table occupancy
	logic               found_q;
	logic [VALUE_W-1:0] vout_q;
	logic               full_q;
	logic [COUNT_W-1:0] count_q;

	// output register
	logic               out_valid_q;
	logic               out_found_q;
	logic [VALUE_W-1:0] out_vout_q;
	logic               out_status_q;
	logic [COUNT_W-1:0] out_count_q;

	// hash unit and memory hookup
	logic               hash_start;
	logic               hash_done;
	logic [SLOT_W-1:0]  hash_slot;
	slot_rd_t           rd_req;
	slot_wr_t           wr_req;
	slot_word_t         rd_word;

	// control decoded from state and probe data
	logic               accept;
	logic               needs_probe;
	logic               key_hit;
	logic               last_slot;
	logic               tomb_new;
	logic               probe_end;
	logic               load_out;
	logic               dec_found;
	logic [VALUE_W-1:0] dec_vout;
	logic               dec_full;
	logic               dec_insert;
	logic               dec_remove;

	oaht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req.key & KEY_MASK),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	oaht_slot_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.wr_req  (wr_req),
		.rd_word (rd_word)
	);

	// delete on an empty table and unknown ops answer without probing
	assign needs_probe = (req.op == OP_PUT) || (req.op == OP_GET) ||
		((req.op == OP_DEL) && (count_q != '0));
	assign accept = req.valid && req.ready;

	// probe classification of the slot read last cycle
	assign key_hit   = (rd_word.mark == MARK_FILLED) && (rd_word.key == key_q);
	assign last_slot = (probe_cnt_q == SLOT_W'(CAPACITY - 1));
	assign tomb_new  = (rd_word.mark == MARK_TOMB) && !have_tomb_q;
	assign probe_end = (rd_word.mark == MARK_EMPTY) || key_hit || last_slot;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = needs_probe ? ST_HASH : ST_REPLY;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (probe_end) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the fsm: handshake, memory accesses and probe decisions
	always_comb begin
		req.ready  = 1'b0;
		hash_start = 1'b0;
		rd_req     = '0;
		wr_req     = '0;
		load_out   = 1'b0;
		dec_found  = 1'b0;
		dec_vout   = '0;
		dec_full   = 1'b0;
		dec_insert = 1'b0;
		dec_remove = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready  = 1'b1;
				hash_start = req.valid && needs_probe;
			end
			ST_HASH: begin
				if (hash_done) begin
					rd_req.en   = 1'b1;
					rd_req.addr = hash_slot;
				end
			end
			ST_PROBE: begin
				if (!probe_end) begin
					// linear step, wraps with the slot index width
					rd_req.en   = 1'b1;
					rd_req.addr = idx_q + 1'b1;
				end
				if (rd_word.mark == MARK_EMPTY) begin
					// miss; a put inserts into this first empty slot
					if (op_q == OP_PUT) begin
						dec_insert       = 1'b1;
						wr_req.en        = 1'b1;
						wr_req.addr      = idx_q;
						wr_req.data.mark  = MARK_FILLED;
						wr_req.data.key   = key_q;
						wr_req.data.value = val_q;
					end
				end else if (key_hit) begin
					dec_found = 1'b1;
					if (op_q == OP_PUT) begin
						wr_req.en         = 1'b1;
						wr_req.addr       = idx_q;
						wr_req.data.mark  = MARK_FILLED;
						wr_req.data.key   = key_q;
						wr_req.data.value = val_q;
					end else if (op_q == OP_DEL) begin
						dec_vout          = rd_word.value;
						dec_remove        = 1'b1;
						wr_req.en         = 1'b1;
						wr_req.addr       = idx_q;
						wr_req.data.mark  = MARK_TOMB;
						wr_req.data.key   = rd_word.key;
						wr_req.data.value = rd_word.value;
					end else begin
						dec_vout = rd_word.value;
					end
				end else if (last_slot && (op_q == OP_PUT)) begin
					// whole table walked without an empty slot
					if (have_tomb_q || tomb_new) begin
						dec_insert        = 1'b1;
						wr_req.en         = 1'b1;
						wr_req.addr       = have_tomb_q ? tomb_q : idx_q;
						wr_req.data.mark  = MARK_FILLED;
						wr_req.data.key   = key_q;
						wr_req.data.value = val_q;
					end else begin
						dec_full = 1'b1;
					end
				end
			end
			ST_REPLY: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			have_tomb_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dec_insert) begin
				count_q <= count_q + 1'b1;
			end else if (dec_remove) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == ST_HASH && hash_done) begin
				have_tomb_q <= 1'b0;
			end else if (state_q == ST_PROBE && tomb_new) begin
				have_tomb_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			key_q   <= req.key & KEY_MASK;
			val_q   <= req.value & VALUE_MASK;
			found_q <= 1'b0;
			vout_q  <= '0;
			full_q  <= 1'b0;
		end
		if (state_q == ST_HASH && hash_done) begin
			idx_q       <= hash_slot;
			probe_cnt_q <= '0;
		end
		if (state_q == ST_PROBE) begin
			if (tomb_new) begin
				tomb_q <= idx_q;
			end
			if (probe_end) begin
				found_q <= dec_found;
				vout_q  <= dec_vout;
				full_q  <= dec_full;
			end else begin
				idx_q       <= idx_q + 1'b1;
				probe_cnt_q <= probe_cnt_q + 1'b1;
			end
		end
		if (load_out) begin
			out_found_q  <= found_q;
			out_vout_q   <= vout_q;
			out_status_q <= full_q;
			out_count_q  <= count_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.value_out   = out_vout_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;

	// occupancy never exceeds the slot count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// memory writes only come from a probe decision
	a_write_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		wr_req.en |-> (state_q == ST_PROBE))
		else $error("slot write outside probe");

	// every probe cycle looks at data read in the cycle before
	a_probe_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> $past(rd_req.en))
		else $error("probe without a preceding slot read");

	// a full-table flag comes only from a put
	a_full_put: assert property (@(posedge clk) disable iff (!arst_n)
		dec_full |-> (op_q == OP_PUT) && last_slot)
		else $error("table full flagged outside a put walk");

endmodule

// File: hw/rtl/oaht_hash.sv
// iterative fnv-1a hash unit, one key byte per cycle
module oaht_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [oaht_pkg::KEY_W-1:0]    key,
	output logic                          done,
	output logic [oaht_pkg::SLOT_W-1:0]   slot
);
	import oaht_pkg::*;

	logic                  run_q;
	logic                  done_q;
	logic [BYTE_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]      key_q;
	logic [31:0]           h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BYTE_CNT_W'(KEY_BYTES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// key bytes go in low byte first, shifting zeros in past the key width
	always_ff @(posedge clk) begin
		if (start) begin
			h_q   <= FNV_BASIS;
			key_q <= key;
		end else if (run_q) begin
			h_q   <= fnv_step(h_q, key_q[7:0]);
			key_q <= key_q >> 8;
		end
	end

	assign done = done_q;
	assign slot = h_q[SLOT_W-1:0];

endmodule

// File: hw/rtl/oaht_slot_ram.sv
// slot memory: mark, key and value per slot, with per-slot written flags
module oaht_slot_ram (
	input  logic                  clk,
	input  logic                  arst_n,
	input  oaht_pkg::slot_rd_t    rd_req,
	input  oaht_pkg::slot_wr_t    wr_req,
	output oaht_pkg::slot_word_t  rd_word
);
	import oaht_pkg::*;

	slot_word_t          mem [CAPACITY];
	logic [CAPACITY-1:0] written_q;
	slot_word_t          rd_word_s1;
	logic                rd_written_s1;

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[wr_req.addr] <= wr_req.data;
		end
		if (rd_req.en) begin
			rd_word_s1 <= mem[rd_req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q     <= '0;
			rd_written_s1 <= 1'b0;
		end else begin
			if (wr_req.en) begin
				written_q[wr_req.addr] <= 1'b1;
			end
			if (rd_req.en) begin
				rd_written_s1 <= written_q[rd_req.addr];
			end
		end
	end

	// a slot never written reads as empty
	always_comb begin
		rd_word = rd_word_s1;
		if (!rd_written_s1) begin
			rd_word.mark = MARK_EMPTY;
		end
	end

endmodule

// File: verif/tb_open_addressed_hash_table.sv
// self-checking testbench of the open-addressed hash table with linear probing
`timescale 1ns / 100ps

module tb_open_addressed_hash_table;
	import oaht_pkg::*;

	// op code past delete, the block must answer it without touching the table
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	// fnv-1a constants for the home slot
	localparam logic [31:0] HASH_SEED = 32'h811C_9DC5;
	localparam logic [31:0] HASH_MULT = 32'h0100_0193;

	// run shape
	localparam int POOL_SIZE      = 96;   // more keys than slots, so the table fills up
	localparam int RANDOM_WORDS   = 400;
	localparam int TAIL_WORDS     = 60;   // last words go through with no idling
	localparam int HOLD_AFTER     = 150;  // replies taken before the long receiver hold
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 120;  // wait after the last reply, before the verdict
	localparam int WATCHDOG_LIMIT = 3000; // hold plus several full probes, many times over

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic               found;
		logic [VALUE_W-1:0] value_out;
		logic               status;
		logic [COUNT_W-1:0] entry_count;
	} rsp_word_t;

	logic clk;
	logic arst_n;

	oaht_req_if req ();
	oaht_rsp_if rsp ();

	open_addressed_hash_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// shadow copy of the table, updated as each request word is accepted
	mark_t              tbl_mark  [CAPACITY];
	logic [KEY_W-1:0]   tbl_key   [CAPACITY];
	logic [VALUE_W-1:0] tbl_value [CAPACITY];
	int unsigned        tbl_filled;

	req_word_t   pend_q[$];       // request words not yet offered
	rsp_word_t   due_replies[$];  // replies owed by the block, oldest first
	int unsigned total_words;
	int unsigned sent_cnt;
	int unsigned rcv_cnt;
	int unsigned reply_errors;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned hold_left;
	bit          hold_done;
	int unsigned stuck_cycles;

	// walk the probe sequence of key: true when a usable slot exists, hit tells
	// whether the key sits there; an empty slot ends the walk even after a tombstone
	function automatic bit probe_table(input logic [KEY_W-1:0] key, output int slot,
		output bit hit);
		logic [31:0] h;
		int          home;
		int          idx;
		bit          have_tomb;
		h = HASH_SEED;
		for (int b = 0; b < KEY_BYTES; b++) begin
			h = h ^ ((b < 4) ? {24'd0, key[8*b +: 8]} : 32'd0);
			h = h * HASH_MULT;
		end
		home      = int'(h % CAPACITY);
		hit       = 1'b0;
		slot      = 0;
		have_tomb = 1'b0;
		for (int x = 0; x < CAPACITY; x++) begin
			idx = (home + x) % CAPACITY;
			if (tbl_mark[idx] == MARK_EMPTY) begin
				slot = idx;
				return 1'b1;
			end
			if (tbl_mark[idx] == MARK_FILLED && tbl_key[idx] == key) begin
				hit  = 1'b1;
				slot = idx;
				return 1'b1;
			end
			if (tbl_mark[idx] == MARK_TOMB && !have_tomb) begin
				have_tomb = 1'b1;
				slot      = idx;
			end
		end
		return have_tomb;
	endfunction

	// apply one request word to the shadow table and return the reply it must produce
	function automatic rsp_word_t apply_to_table(input req_word_t w);
		rsp_word_t        r;
		logic [KEY_W-1:0] key;
		int               slot;
		bit               hit;
		bit               ok;
		r   = '0;
		key = w.key & KEY_MASK;
		case (w.op)
			OP_PUT: begin
				ok = probe_table(key, slot, hit);
				if (!ok) begin
					// no empty slot and no tombstone left
					r.status = 1'b1;
				end else if (hit) begin
					tbl_value[slot] = w.value & VALUE_MASK;
					r.found         = 1'b1;
				end else begin
					tbl_key[slot]   = key;
					tbl_value[slot] = w.value & VALUE_MASK;
					tbl_mark[slot]  = MARK_FILLED;
					tbl_filled++;
				end
			end
			OP_GET: begin
				ok = probe_table(key, slot, hit);
				if (ok && hit) begin
					r.found     = 1'b1;
					r.value_out = tbl_value[slot];
				end
			end
			OP_DEL: begin
				// an empty table skips the probe entirely
				if (tbl_filled != 0) begin
					ok = probe_table(key, slot, hit);
					if (ok && hit) begin
						r.found        = 1'b1;
						r.value_out    = tbl_value[slot];
						tbl_mark[slot] = MARK_TOMB;
						tbl_filled--;
					end
				end
			end
			default: begin
				// unknown op: table untouched, only the count is reported
			end
		endcase
		r.entry_count = COUNT_W'(tbl_filled);
		return r;
	endfunction

	task automatic add_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input logic [VALUE_W-1:0] value);
		req_word_t w;
		w.op    = op;
		w.key   = key;
		w.value = value;
		pend_q.push_back(w);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver: offers queued words, idles in short bursts between them
	always @(posedge clk or negedge arst_n) begin : p_drive
		req_word_t w;
		bit        may_idle;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op    <= '0;
			req.key   <= '0;
			req.value <= '0;
			send_gap  = 0;
		end else if (!req.valid || req.ready) begin
			// word taken at this edge: predict its reply now, in acceptance order
			if (req.valid) begin
				w.op    = req.op;
				w.key   = req.key;
				w.value = req.value;
				due_replies.push_back(apply_to_table(w));
				sent_cnt++;
			end
			// idle windows alternate with quiet stretches, none in the tail
			may_idle = (sent_cnt + TAIL_WORDS < total_words) && ((sent_cnt / 64) % 3 != 2);
			if (send_gap != 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (may_idle && $urandom_range(0, 99) < 15) begin
				send_gap = $urandom_range(0, 4);
				req.valid <= 1'b0;
			end else if (pend_q.size() != 0) begin
				w = pend_q.pop_front();
				req.valid <= 1'b1;
				req.op    <= w.op;
				req.key   <= w.key;
				req.value <= w.value;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// reply monitor: checks each reply against the oldest one owed, drives ready
	always @(posedge clk or negedge arst_n) begin : p_receive
		rsp_word_t got;
		rsp_word_t want;
		bit        may_stall;
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			recv_stall = 0;
			hold_left  = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.found       = rsp.found;
				got.value_out   = rsp.value_out;
				got.status      = rsp.status;
				got.entry_count = rsp.entry_count;
				rcv_cnt++;
				if (due_replies.size() == 0) begin
					reply_errors++;
					if (reply_errors <= 10)
						$display("reply %0d with none owed: found %0b value_out %h status %0b count %0d",
							rcv_cnt, got.found, got.value_out, got.status, got.entry_count);
				end else begin
					want = due_replies.pop_front();
					if (got !== want) begin
						reply_errors++;
						if (reply_errors <= 10)
							$display({"reply %0d mismatch: expected found %0b value_out %h status %0b ",
								"count %0d, got found %0b value_out %h status %0b count %0d"},
								rcv_cnt, want.found, want.value_out, want.status, want.entry_count,
								got.found, got.value_out, got.status, got.entry_count);
					end
				end
			end
			may_stall = (rcv_cnt + TAIL_WORDS < total_words) && ((rcv_cnt / 64) % 3 != 1);
			if (hold_left != 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (!hold_done && rcv_cnt >= HOLD_AFTER) begin
				// long hold: the sender keeps offering, so the block backs up its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp.ready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				rsp.ready <= 1'b0;
			end else if (may_stall && $urandom_range(0, 99) < 15) begin
				recv_stall = $urandom_range(0, 4);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles where no word moves on either channel
	always @(posedge clk) begin : p_watchdog
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : p_main
		logic [KEY_W-1:0] key_pool[$];
		bit               key_seen[logic [KEY_W-1:0]];
		logic [KEY_W-1:0] k;
		logic [OP_W-1:0]  op;
		int unsigned      r;

		arst_n    = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			tbl_mark[i]  = MARK_EMPTY;
			tbl_key[i]   = '0;
			tbl_value[i] = '0;
		end
		tbl_filled = 0;

		// distinct random keys, enough to overflow the table
		while (key_pool.size() < POOL_SIZE) begin
			k = $urandom;
			if (!key_seen.exists(k)) begin
				key_seen[k] = 1'b1;
				key_pool.push_back(k);
			end
		end

		// directed: misses and delete on an empty table, unknown op, field extremes,
		// update in place, delete hit and miss, reinsert past a tombstone
		add_word(OP_GET,  32'h0000_0000, 32'h0000_0000);
		add_word(OP_DEL,  32'h0000_0000, 32'hFFFF_FFFF);
		add_word(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(OP_PUT,  32'h0000_0000, 32'h0000_0000);
		add_word(OP_PUT,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(OP_GET,  32'h0000_0000, 32'hFFFF_FFFF);
		add_word(OP_GET,  32'hFFFF_FFFF, 32'h0000_0000);
		add_word(OP_PUT,  32'h0000_0000, 32'h5A5A_5A5A);
		add_word(OP_GET,  32'h0000_0000, 32'h0000_0000);
		add_word(OP_DEL,  32'hFFFF_FFFF, 32'h0000_0000);
		add_word(OP_GET,  32'hFFFF_FFFF, 32'h0000_0000);
		add_word(OP_DEL,  32'hFFFF_FFFF, 32'h0000_0000);
		add_word(OP_PUT,  32'hFFFF_FFFF, 32'h0000_0001);
		add_word(OP_NONE, 32'h0000_0000, 32'h0000_0000);
		add_word(OP_PUT,  32'h1234_5678, 32'hA5A5_A5A5);
		add_word(OP_GET,  32'h8765_4321, 32'h0000_0000);
		add_word(OP_GET,  32'hFFFF_FFFF, 32'h0000_0000);
		add_word(OP_DEL,  32'h0000_0000, 32'h0000_0000);
		add_word(OP_DEL,  32'h1234_5678, 32'h0000_0000);
		add_word(OP_DEL,  32'hFFFF_FFFF, 32'h0000_0000);
		add_word(OP_GET,  32'h0000_0000, 32'h0000_0000);
		add_word(OP_NONE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);

		// fill every slot, then overflow: full-table put, full-length misses,
		// then free a few slots and insert into the tombstones
		for (int i = 0; i < CAPACITY; i++)
			add_word(OP_PUT, key_pool[i], $urandom);
		add_word(OP_PUT, key_pool[CAPACITY], $urandom);
		add_word(OP_GET, key_pool[CAPACITY], $urandom);
		add_word(OP_DEL, key_pool[CAPACITY], $urandom);
		add_word(OP_GET, key_pool[CAPACITY - 1], $urandom);
		for (int i = 0; i < 4; i++)
			add_word(OP_DEL, key_pool[$urandom_range(0, CAPACITY - 1)], $urandom);
		add_word(OP_PUT, key_pool[CAPACITY], $urandom);
		add_word(OP_PUT, key_pool[CAPACITY + 1], $urandom);
		add_word(OP_GET, key_pool[CAPACITY + 1], $urandom);

		// random mix over the key pool with some stray keys; puts outweigh deletes
		// so the table hovers near full and keeps hitting long probes
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 48)
				op = OP_PUT;
			else if (r < 74)
				op = OP_GET;
			else if (r < 95)
				op = OP_DEL;
			else
				op = OP_NONE;
			k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) :
				key_pool[$urandom_range(0, POOL_SIZE - 1)];
			add_word(op, k, $urandom);
		end
		total_words = pend_q.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// run until every word is sent and every reply has come back
		while (pend_q.size() != 0 || req.valid || due_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (reply_errors == 0 && due_replies.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
